// ===== rtl/core/tccs_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console package
// Shared constants, request codes, the result record and the hex digit helper.
// ----------------------------------------------------------------------------
`default_nettype none

package tccs_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int POS_W  = 11;
    localparam int CHAR_W = 8;
    localparam int ACT_W  = 3;
    localparam int HEX_W  = 32;
    localparam int CELL_W = 16;

    localparam logic [ACT_W-1:0] ACT_PRINT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MOVE  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_HEX   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ  = 3'd4;

    localparam logic [CHAR_W-1:0] TEXT_ATTR  = 8'h07;
    localparam logic [CHAR_W-1:0] NEWLINE    = 8'h0a;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0700;

    // Characters still to come after the leading zero of a hex request.
    localparam logic [3:0] HEX_TAIL = 4'd9;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_attr;
        logic [CHAR_W-1:0] cell_char;
        logic [POS_W-1:0]  cursor_position;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
    } res_t;

    function automatic logic [CHAR_W-1:0] hex_ascii(input logic [3:0] d);
        logic [CHAR_W-1:0] r;
        if (d <= 4'd9) begin
            r = CHAR_ZERO + {4'h0, d};
        end else begin
            r = CHAR_A + {4'h0, d} - 8'd10;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tccs_screen_ram.sv =====
// ----------------------------------------------------------------------------
// Screen cell memory
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_screen_ram #(
    parameter int DEPTH = tccs_pkg::COLUMNS_DEF * tccs_pkg::ROWS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                        aclk,
    input  wire logic                        we,
    input  wire logic [AW-1:0]               waddr,
    input  wire logic [tccs_pkg::CELL_W-1:0] wdata,
    input  wire logic                        re,
    input  wire logic [AW-1:0]               raddr,
    output logic      [tccs_pkg::CELL_W-1:0] rdata
);

    logic [tccs_pkg::CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tccs_engine.sv =====
// ----------------------------------------------------------------------------
// Console engine
// Sequencer that owns the cursor and the scroll origin, and drives the screen
// memory for printing, scrolling, clearing and cell reads.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_engine #(
    parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccs_pkg::ROWS_DEF,
    parameter int CELLS   = COLUMNS * ROWS,
    parameter int AW      = $clog2(CELLS)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [tccs_pkg::ACT_W-1:0]  in_action,
    input  wire logic [tccs_pkg::CHAR_W-1:0] in_char,
    input  wire logic [tccs_pkg::HEX_W-1:0]  in_hex,
    input  wire logic [tccs_pkg::COL_W-1:0]  in_col,
    input  wire logic [tccs_pkg::ROW_W-1:0]  in_row,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output tccs_pkg::res_t                   res,
    output logic                             mem_we,
    output logic      [AW-1:0]               mem_waddr,
    output logic      [tccs_pkg::CELL_W-1:0] mem_wdata,
    output logic                             mem_re,
    output logic      [AW-1:0]               mem_raddr,
    input  wire logic [tccs_pkg::CELL_W-1:0] mem_rdata
);

    localparam int COL_W  = tccs_pkg::COL_W;
    localparam int ROW_W  = tccs_pkg::ROW_W;
    localparam int CHAR_W = tccs_pkg::CHAR_W;
    localparam int HEX_W  = tccs_pkg::HEX_W;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_PUT,
        ST_SCROLL,
        ST_READ,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic                init_reg, init_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [ROW_W-1:0]    top_reg, top_next;
    logic [AW-1:0]       sweep_reg, sweep_next;
    logic [COL_W-1:0]    scol_reg, scol_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic [HEX_W-1:0]    hex_reg, hex_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic [CHAR_W-1:0]   rd_char_reg, rd_char_next;
    logic [CHAR_W-1:0]   rd_attr_reg, rd_attr_next;

    logic                accept;
    logic [COL_W-1:0]    clamp_col;
    logic [ROW_W-1:0]    clamp_row;
    logic                is_newline;
    logic [COL_W-1:0]    put_col;
    logic [ROW_W-1:0]    put_row;
    logic                put_scroll;
    logic [CHAR_W-1:0]   fetch_char;

    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                  input logic [ROW_W-1:0] t);
        logic [ROW_W:0] s;
        s = {1'b0, r} + {1'b0, t};
        if (s >= (ROW_W+1)'(ROWS)) begin
            s = s - (ROW_W+1)'(ROWS);
        end
        return s[ROW_W-1:0];
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
        return AW'(r * COLUMNS + c);
    endfunction

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && res_ready);
    assign res_valid = (state_reg == ST_DONE);

    assign clamp_col = (in_col > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : in_col;
    assign clamp_row = (in_row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : in_row;

    assign is_newline = (char_reg == tccs_pkg::NEWLINE);
    assign fetch_char = (cnt_reg == tccs_pkg::HEX_TAIL) ? tccs_pkg::CHAR_X
                                                        : tccs_pkg::hex_ascii(hex_reg[HEX_W-1 -: 4]);

    always_comb begin
        if (is_newline) begin
            put_col = '0;
            put_row = row_reg + 1'b1;
        end else begin
            put_col = col_reg + 1'b1;
            put_row = row_reg;
        end
        if (put_col >= COL_W'(COLUMNS)) begin
            put_col = '0;
            put_row = put_row + 1'b1;
        end
        put_scroll = (put_row >= ROW_W'(ROWS));
    end

    always_comb begin
        state_next   = state_reg;
        init_next    = init_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        top_next     = top_reg;
        sweep_next   = sweep_reg;
        scol_next    = scol_reg;
        char_next    = char_reg;
        hex_next     = hex_reg;
        cnt_next     = cnt_reg;
        rd_char_next = rd_char_reg;
        rd_attr_next = rd_attr_reg;
        mem_we       = 1'b0;
        mem_waddr    = cell_addr(phys_row(row_reg, top_reg), col_reg);
        mem_wdata    = {tccs_pkg::TEXT_ATTR, char_reg};
        mem_re       = 1'b0;
        mem_raddr    = cell_addr(phys_row(clamp_row, top_reg), clamp_col);

        unique case (state_reg)
            ST_SWEEP: begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                mem_wdata  = tccs_pkg::BLANK_CELL;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == AW'(CELLS - 1)) begin
                    sweep_next = '0;
                    init_next  = 1'b0;
                    state_next = init_reg ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE, ST_DONE: begin
                if (state_reg == ST_DONE && res_ready) begin
                    state_next = ST_IDLE;
                end
                if (accept) begin
                    rd_char_next = '0;
                    rd_attr_next = '0;
                    unique case (in_action)
                        tccs_pkg::ACT_PRINT: begin
                            char_next  = in_char;
                            cnt_next   = '0;
                            state_next = ST_PUT;
                        end
                        tccs_pkg::ACT_CLEAR: begin
                            col_next   = '0;
                            row_next   = '0;
                            top_next   = '0;
                            sweep_next = '0;
                            state_next = ST_SWEEP;
                        end
                        tccs_pkg::ACT_MOVE: begin
                            col_next   = clamp_col;
                            row_next   = clamp_row;
                            state_next = ST_DONE;
                        end
                        tccs_pkg::ACT_HEX: begin
                            char_next  = tccs_pkg::CHAR_ZERO;
                            hex_next   = in_hex;
                            cnt_next   = tccs_pkg::HEX_TAIL;
                            state_next = ST_PUT;
                        end
                        tccs_pkg::ACT_READ: begin
                            mem_re     = 1'b1;
                            state_next = ST_READ;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                rd_char_next = mem_rdata[CHAR_W-1:0];
                rd_attr_next = mem_rdata[tccs_pkg::CELL_W-1:CHAR_W];
                state_next   = ST_DONE;
            end
            ST_PUT: begin
                mem_we = !is_newline;
                if (put_scroll) begin
                    col_next   = '0;
                    row_next   = ROW_W'(ROWS - 1);
                    scol_next  = '0;
                    state_next = ST_SCROLL;
                end else begin
                    col_next = put_col;
                    row_next = put_row;
                    if (cnt_reg != '0) begin
                        char_next = fetch_char;
                        cnt_next  = cnt_reg - 1'b1;
                        if (cnt_reg != tccs_pkg::HEX_TAIL) begin
                            hex_next = hex_reg << 4;
                        end
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCROLL: begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(top_reg, scol_reg);
                mem_wdata = tccs_pkg::BLANK_CELL;
                scol_next = scol_reg + 1'b1;
                if (scol_reg == COL_W'(COLUMNS - 1)) begin
                    scol_next  = '0;
                    top_next   = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;
                    state_next = ST_DONE;
                    if (cnt_reg != '0) begin
                        char_next  = fetch_char;
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = ST_PUT;
                        if (cnt_reg != tccs_pkg::HEX_TAIL) begin
                            hex_next = hex_reg << 4;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SWEEP;
            init_reg  <= 1'b1;
            col_reg   <= '0;
            row_reg   <= '0;
            top_reg   <= '0;
            sweep_reg <= '0;
            scol_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            init_reg  <= init_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            top_reg   <= top_next;
            sweep_reg <= sweep_next;
            scol_reg  <= scol_next;
            cnt_reg   <= cnt_next;
        end
        char_reg    <= char_next;
        hex_reg     <= hex_next;
        rd_char_reg <= rd_char_next;
        rd_attr_reg <= rd_attr_next;
    end

    assign res.cursor_col      = col_reg;
    assign res.cursor_row      = row_reg;
    assign res.cursor_position = tccs_pkg::POS_W'(row_reg * COLUMNS + col_reg);
    assign res.cell_char       = rd_char_reg;
    assign res.cell_attr       = rd_attr_reg;

endmodule

`default_nettype wire

// ===== rtl/core/text_console_cursor_scroll_unit.sv =====
// ----------------------------------------------------------------------------
// Text console with cursor and scrolling
// Top level: request decode, engine, screen memory and the result register.
// ----------------------------------------------------------------------------
// Each request gives one result holding the cursor after the request. A
// request that pushes the cursor past the bottom row also scrolls the screen:
// the screen memory scrolls by moving its row origin and then blanking the
// new bottom row one cell a cycle through its single write port. A clear
// blanks every cell, and after reset the block blanks the memory before it
// takes its first request.
// A finished result waits in an output register, so the next request can
// start while it is still held.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_scroll_unit #(
    parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // char_code[7:0], hex_value[39:8], column[46:40], row[51:47]
    input  wire logic [55:0] s_tdata,
    // action[2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // cursor_col[6:0], cursor_row[11:7], cursor_position[22:12],
    // cell_char[30:23], cell_attr[38:31]
    output logic [39:0]      m_tdata
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    logic                        res_valid;
    logic                        res_ready;
    tccs_pkg::res_t              res;
    tccs_pkg::res_t              m_res_reg;
    logic                        m_valid_reg;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [tccs_pkg::CELL_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;
    logic [tccs_pkg::CELL_W-1:0] mem_rdata;

    tccs_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .CELLS   (CELLS),
        .AW      (AW)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_char   (s_tdata[7:0]),
        .in_hex    (s_tdata[39:8]),
        .in_col    (s_tdata[46:40]),
        .in_row    (s_tdata[51:47]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    tccs_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_screen_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_res_reg};

    // The memory is blanked after reset before any request is taken.
    a_no_request_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("request taken during the clearing pass");

    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_res_reg.cursor_col < tccs_pkg::COL_W'(COLUMNS))
                  && (m_res_reg.cursor_row < tccs_pkg::ROW_W'(ROWS)))
        else $error("cursor outside the screen");

    a_position_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_res_reg.cursor_position ==
            tccs_pkg::POS_W'(m_res_reg.cursor_row * COLUMNS + m_res_reg.cursor_col))
        else $error("cursor position does not match row and column");

endmodule

`default_nettype wire

// ===== dv/text_console_cursor_scroll_unit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console checker
// Watches both channels of the console. It keeps its own copy of the screen
// and the cursor, works out the result of every accepted request, and
// compares each returned result with the oldest result still owed.
// ----------------------------------------------------------------------------

module text_console_cursor_scroll_unit_checker #(
    parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    output int          mismatch_count,
    output int          results_owed
);

    localparam int CELLS = COLUMNS * ROWS;

    logic [tccs_pkg::CELL_W-1:0] screen [CELLS];
    int                          cur_col;
    int                          cur_row;
    tccs_pkg::res_t              owed_results [$];

    function automatic int cell_addr(int col, int row);
        int a;
        a = row * COLUMNS + col;
        return (a >= CELLS) ? 0 : a;
    endfunction

    function automatic int clamp_coord(int v, int size);
        return (v > size - 1) ? size - 1 : v;
    endfunction

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++) begin
            screen[i] = tccs_pkg::BLANK_CELL;
        end
    endfunction

    function automatic void scroll_screen();
        for (int i = 0; i < CELLS - COLUMNS; i++) begin
            screen[i] = screen[i + COLUMNS];
        end
        for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
            screen[i] = tccs_pkg::BLANK_CELL;
        end
    endfunction

    function automatic void emit_char(logic [tccs_pkg::CHAR_W-1:0] ch);
        if (ch == tccs_pkg::NEWLINE) begin
            cur_col = 0;
            cur_row++;
        end else begin
            screen[cell_addr(cur_col, cur_row)] = {tccs_pkg::TEXT_ATTR, ch};
            cur_col++;
        end
        if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= ROWS) begin
            scroll_screen();
            cur_row = ROWS - 1;
            cur_col = 0;
        end
    endfunction

    function automatic tccs_pkg::res_t predict_request(logic [tccs_pkg::ACT_W-1:0] action,
                                                       logic [55:0] data);
        logic [tccs_pkg::HEX_W-1:0]  hex;
        logic [3:0]                  nib;
        logic [tccs_pkg::CELL_W-1:0] cell_word;
        int                          col;
        int                          row;
        tccs_pkg::res_t              r;
        hex       = data[39:8];
        col       = clamp_coord(int'(data[46:40]), COLUMNS);
        row       = clamp_coord(int'(data[51:47]), ROWS);
        cell_word = '0;
        case (action)
            tccs_pkg::ACT_PRINT: begin
                emit_char(data[7:0]);
            end
            tccs_pkg::ACT_CLEAR: begin
                blank_screen();
                cur_col = 0;
                cur_row = 0;
            end
            tccs_pkg::ACT_MOVE: begin
                cur_col = col;
                cur_row = row;
            end
            tccs_pkg::ACT_HEX: begin
                emit_char(tccs_pkg::CHAR_ZERO);
                emit_char(tccs_pkg::CHAR_X);
                for (int k = 7; k >= 0; k--) begin
                    nib = hex[4*k +: 4];
                    emit_char((nib <= 4'd9) ? tccs_pkg::CHAR_ZERO + nib
                                            : tccs_pkg::CHAR_A + nib - 8'd10);
                end
            end
            tccs_pkg::ACT_READ: begin
                cell_word = screen[cell_addr(col, row)];
            end
            default: begin
            end
        endcase
        r.cursor_col      = cur_col[tccs_pkg::COL_W-1:0];
        r.cursor_row      = cur_row[tccs_pkg::ROW_W-1:0];
        r.cursor_position = tccs_pkg::POS_W'(cur_row * COLUMNS + cur_col);
        r.cell_char       = cell_word[7:0];
        r.cell_attr       = cell_word[15:8];
        return r;
    endfunction

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin : monitor
        tccs_pkg::res_t got;
        tccs_pkg::res_t want;
        if (!aresetn) begin
            blank_screen();
            cur_col = 0;
            cur_row = 0;
            owed_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                owed_results.push_back(predict_request(s_tuser, s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got = tccs_pkg::res_t'(m_tdata[$bits(tccs_pkg::res_t)-1:0]);
                if (owed_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with none owed, expected nothing, actual %h",
                             $time, got);
                end else begin
                    want = owed_results.pop_front();
                    check_field("cursor_col", want.cursor_col, got.cursor_col);
                    check_field("cursor_row", want.cursor_row, got.cursor_row);
                    check_field("cursor_position", want.cursor_position,
                                got.cursor_position);
                    check_field("cell_char", want.cell_char, got.cell_char);
                    check_field("cell_attr", want.cell_attr, got.cell_attr);
                end
            end
        end
        results_owed = owed_results.size();
    end

endmodule

// ===== dv/text_console_cursor_scroll_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console testbench
// Drives directed and random console requests with varying gaps on both
// channels, forces long result stalls and full drains, and reports the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------

module text_console_cursor_scroll_unit_test;

    localparam int STALL_LIMIT      = 20000;
    localparam int HOLDOFF_CYCLES   = 400;
    localparam int RANDOM_PER_PHASE = 510;
    localparam int DRAIN_CYCLES     = 100;

    localparam logic [tccs_pkg::ACT_W-1:0] ACT_SPARE_FIRST = tccs_pkg::ACT_READ + 3'd1;
    localparam logic [tccs_pkg::ACT_W-1:0] ACT_SPARE_LAST  = '1;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    int mismatch_count;
    int results_owed;
    int tx_idle_pct;
    int rx_idle_pct;
    int holdoff_requests;
    int holdoff_served;
    int quiet_cycles;

    always #4 aclk = ~aclk;

    text_console_cursor_scroll_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    text_console_cursor_scroll_unit_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The receiver serves each long hold-off asked for by the sender.
    initial begin
        forever begin
            @(negedge aclk);
            if (holdoff_served != holdoff_requests) begin
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge aclk);
                holdoff_served++;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_request(logic [tccs_pkg::ACT_W-1:0] action,
                                logic [tccs_pkg::CHAR_W-1:0] ch,
                                logic [tccs_pkg::HEX_W-1:0] hex,
                                logic [tccs_pkg::COL_W-1:0] col,
                                logic [tccs_pkg::ROW_W-1:0] row);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tuser  <= action;
        s_tdata  <= {4'b0000, row, col, hex, ch};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (results_owed != 0);
    endtask

    task automatic send_random_request();
        int                          pick;
        logic [tccs_pkg::ACT_W-1:0]  action;
        logic [tccs_pkg::CHAR_W-1:0] ch;
        logic [tccs_pkg::COL_W-1:0]  col;
        logic [tccs_pkg::ROW_W-1:0]  row;
        pick = $urandom_range(99);
        ch   = tccs_pkg::CHAR_W'($urandom_range(255));
        col  = tccs_pkg::COL_W'($urandom_range(127));
        row  = tccs_pkg::ROW_W'($urandom_range(31));
        if (pick < 35) begin
            action = tccs_pkg::ACT_PRINT;
            if ($urandom_range(4) == 0) begin
                ch = tccs_pkg::NEWLINE;
            end
        end else if (pick < 47) begin
            action = tccs_pkg::ACT_HEX;
        end else if (pick < 62) begin
            action = tccs_pkg::ACT_MOVE;
            if ($urandom_range(1) == 1) begin
                col = tccs_pkg::COL_W'($urandom_range(127, 60));
                row = tccs_pkg::ROW_W'($urandom_range(31, 20));
            end
        end else if (pick < 82) begin
            action = tccs_pkg::ACT_READ;
            if ($urandom_range(1) == 1) begin
                row = tccs_pkg::ROW_W'($urandom_range(31, 18));
            end
        end else if (pick < 86) begin
            action = tccs_pkg::ACT_W'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
        end else if (pick == 86) begin
            action = tccs_pkg::ACT_CLEAR;
        end else begin
            action = tccs_pkg::ACT_W'($urandom_range(ACT_SPARE_LAST));
        end
        send_request(action, ch, $urandom, col, row);
    endtask

    initial begin
        tx_idle_pct = 16;
        rx_idle_pct = 85;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        send_request(tccs_pkg::ACT_READ, 8'h00, 32'h0, 7'd0, 5'd0);
        send_request(tccs_pkg::ACT_PRINT, 8'h00, 32'h0, 7'd0, 5'd0);
        send_request(tccs_pkg::ACT_PRINT, 8'hff, 32'hffffffff, 7'd127, 5'd31);
        send_request(tccs_pkg::ACT_PRINT, tccs_pkg::NEWLINE, 32'h0, 7'd0, 5'd0);
        send_request(tccs_pkg::ACT_READ, 8'h00, 32'h0, 7'd0, 5'd0);
        send_request(tccs_pkg::ACT_READ, 8'h00, 32'h0, 7'd1, 5'd0);
        send_request(tccs_pkg::ACT_MOVE, 8'h00, 32'h0, 7'd127, 5'd31);
        send_request(tccs_pkg::ACT_READ, 8'h00, 32'h0, 7'd127, 5'd31);
        send_request(tccs_pkg::ACT_PRINT, 8'h41, 32'h0, 7'd0, 5'd0);
        send_request(tccs_pkg::ACT_READ, 8'h00, 32'h0, 7'd79, 5'd23);
        send_request(tccs_pkg::ACT_MOVE, 8'h00, 32'h0, 7'd79, 5'd0);
        send_request(tccs_pkg::ACT_PRINT, 8'h7e, 32'h0, 7'd0, 5'd0);
        send_request(tccs_pkg::ACT_MOVE, 8'h00, 32'h0, 7'd76, 5'd24);
        send_request(tccs_pkg::ACT_HEX, 8'h00, 32'hffffffff, 7'd0, 5'd0);
        send_request(tccs_pkg::ACT_HEX, 8'h00, 32'h00000000, 7'd0, 5'd0);
        send_request(tccs_pkg::ACT_HEX, 8'h00, 32'h89abcdef, 7'd0, 5'd0);
        send_request(tccs_pkg::ACT_READ, 8'h00, 32'h0, 7'd5, 5'd24);
        send_request(tccs_pkg::ACT_MOVE, 8'h00, 32'h0, 7'd0, 5'd24);
        send_request(tccs_pkg::ACT_PRINT, tccs_pkg::NEWLINE, 32'h0, 7'd0, 5'd0);
        send_request(ACT_SPARE_FIRST, 8'hff, 32'hffffffff, 7'd127, 5'd31);
        send_request(ACT_SPARE_LAST, 8'h00, 32'h0, 7'd0, 5'd0);
        send_request(tccs_pkg::ACT_CLEAR, 8'h00, 32'h0, 7'd0, 5'd0);
        send_request(tccs_pkg::ACT_READ, 8'h00, 32'h0, 7'd79, 5'd23);
        send_request(tccs_pkg::ACT_MOVE, 8'h00, 32'h0, 7'd79, 5'd24);
        wait_for_drain();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 16;
                    rx_idle_pct = 85;
                end
                1: begin
                    tx_idle_pct = 85;
                    rx_idle_pct = 16;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                if (i == RANDOM_PER_PHASE / 2) begin
                    holdoff_requests++;
                end
                send_random_request();
            end
            wait_for_drain();
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
